[rtl/sts_pkg.sv]
// Shared types, constants and functions of the script token scanner.
// Used by the front end, the token queue and the top level.
`timescale 1ns / 1ps
package sts_pkg;

  localparam int OFFSET_WIDTH = 20;
  localparam int LENGTH_WIDTH = 16;
  localparam int LINE_WIDTH   = 16;
  localparam int WORD_DEPTH   = 7;
  localparam int KIND_WIDTH   = 6;
  localparam int QUEUE_DEPTH  = 8;
  localparam int QUEUE_AW     = 3;

  localparam logic [LENGTH_WIDTH-1:0] LEN_MAX  = '1;
  localparam logic [LINE_WIDTH-1:0]   LINE_MAX = '1;

  localparam logic [KIND_WIDTH-1:0] K_IDENT  = 6'd0;
  localparam logic [KIND_WIDTH-1:0] K_NUMBER = 6'd1;
  localparam logic [KIND_WIDTH-1:0] K_STRING = 6'd2;
  localparam logic [KIND_WIDTH-1:0] K_KW0    = 6'd3;
  localparam logic [KIND_WIDTH-1:0] K_OP0    = 6'd20;
  localparam logic [KIND_WIDTH-1:0] K_DOT    = 6'd26;
  localparam logic [KIND_WIDTH-1:0] K_SLASH  = 6'd29;
  localparam logic [KIND_WIDTH-1:0] K_BANG   = 6'd33;
  localparam logic [KIND_WIDTH-1:0] K_EQUAL  = 6'd35;
  localparam logic [KIND_WIDTH-1:0] K_LESS   = 6'd37;
  localparam logic [KIND_WIDTH-1:0] K_GREATER = 6'd39;
  localparam logic [KIND_WIDTH-1:0] K_EOF    = 6'd41;
  localparam logic [KIND_WIDTH-1:0] K_BAD    = 6'd42;
  localparam logic [KIND_WIDTH-1:0] K_UNTERM = 6'd43;

  typedef enum logic [3:0] {
    M_IDLE, M_IDENT, M_NUMBER, M_NUMDOT, M_FRACTION,
    M_STRING, M_SLASH, M_COMMENT, M_OP2
  } scan_mode_t;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       end_marker;
  } char_item_t;

  typedef struct packed {
    logic [KIND_WIDTH-1:0]   token_kind;
    logic [OFFSET_WIDTH-1:0] token_start;
    logic [LENGTH_WIDTH-1:0] token_length;
    logic [LINE_WIDTH-1:0]   token_line;
    logic                    last_of_run;
  } token_t;

  // Up to three tokens leave the scanner per character.
  typedef struct packed {
    logic [1:0] count;
    token_t     t0;
    token_t     t1;
    token_t     t2;
  } token_group_t;

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic [LENGTH_WIDTH-1:0] len_inc(input logic [LENGTH_WIDTH-1:0] v);
    return (v == LEN_MAX) ? v : v + 1'b1;
  endfunction

  function automatic logic [LINE_WIDTH-1:0] line_inc(input logic [LINE_WIDTH-1:0] v);
    return (v == LINE_MAX) ? v : v + 1'b1;
  endfunction

  // Single-character operator kind, or K_BAD when the byte is none of them.
  function automatic logic [KIND_WIDTH-1:0] single_kind(input logic [7:0] c);
    logic [KIND_WIDTH-1:0] k;
    case (c)
      "(": k = K_OP0;
      ")": k = K_OP0 + 6'd1;
      "{": k = K_OP0 + 6'd2;
      "}": k = K_OP0 + 6'd3;
      ";": k = K_OP0 + 6'd4;
      ",": k = K_OP0 + 6'd5;
      ".": k = K_DOT;
      "-": k = K_OP0 + 6'd7;
      "+": k = K_OP0 + 6'd8;
      "/": k = K_SLASH;
      "*": k = K_OP0 + 6'd10;
      "?": k = K_OP0 + 6'd11;
      ":": k = K_OP0 + 6'd12;
      default: k = K_BAD;
    endcase
    return k;
  endfunction

  function automatic logic [KIND_WIDTH-1:0] op2_kind(input logic [7:0] p, input logic eq);
    logic [KIND_WIDTH-1:0] b;
    case (p)
      "!": b = K_BANG;
      "=": b = K_EQUAL;
      "<": b = K_LESS;
      default: b = K_GREATER;
    endcase
    return b + {5'd0, eq};
  endfunction

  // Keyword match over the stored first bytes of an identifier.
  function automatic logic [KIND_WIDTH-1:0] ident_kind(input logic [8*WORD_DEPTH-1:0] w,
                                                       input logic [LENGTH_WIDTH-1:0] n);
    logic [KIND_WIDTH-1:0] k;
    logic [55:0] m3, m2, m4, m5, m6, m7;
    k  = K_IDENT;
    m2 = {40'd0, w[15:0]};
    m3 = {32'd0, w[23:0]};
    m4 = {24'd0, w[31:0]};
    m5 = {16'd0, w[39:0]};
    m6 = {8'd0, w[47:0]};
    m7 = w;
    // w holds byte 0 in the low bits, so literals are written reversed.
    case (n)
      16'd2: begin
        if (m2 == {40'd0, "fi"}) k = K_KW0 + 6'd8;
        else if (m2 == {40'd0, "ro"}) k = K_KW0 + 6'd10;
      end
      16'd3: begin
        if (m3 == {32'd0, "dna"}) k = K_KW0;
        else if (m3 == {32'd0, "rof"}) k = K_KW0 + 6'd6;
        else if (m3 == {32'd0, "tel"}) k = K_KW0 + 6'd15;
      end
      16'd4: begin
        if (m4 == {24'd0, "esle"}) k = K_KW0 + 6'd4;
        else if (m4 == {24'd0, "llun"}) k = K_KW0 + 6'd9;
        else if (m4 == {24'd0, "eurt"}) k = K_KW0 + 6'd14;
      end
      16'd5: begin
        if (m5 == {16'd0, "kaerb"}) k = K_KW0 + 6'd1;
        else if (m5 == {16'd0, "zzalc"}) k = K_KW0 + 6'd2;
        else if (m5 == {16'd0, "eslaf"}) k = K_KW0 + 6'd5;
        else if (m5 == {16'd0, "tcnuf"}) k = K_KW0 + 6'd7;
        else if (m5 == {16'd0, "repus"}) k = K_KW0 + 6'd12;
        else if (m5 == {16'd0, "elihw"}) k = K_KW0 + 6'd16;
      end
      16'd6: begin
        if (m6 == {8'd0, "nruter"}) k = K_KW0 + 6'd11;
        else if (m6 == {8'd0, "citats"}) k = K_KW0 + 6'd13;
      end
      16'd7: begin
        if (m7 == "elosnoc") k = K_KW0 + 6'd3;
      end
      default: k = K_IDENT;
    endcase
    return k;
  endfunction

endpackage

[rtl/sts_front.sv]
// Scanner front end: takes one character per cycle while take is high and forms token groups.
// Depends on sts_pkg.
`timescale 1ns / 1ps
module sts_front import sts_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         take,
  input  char_item_t   item,
  output token_group_t group
);

  scan_mode_t              mode, mode_next;
  logic [OFFSET_WIDTH-1:0] tok_begin, tok_begin_next;
  logic [OFFSET_WIDTH-1:0] pos;
  logic [LINE_WIDTH-1:0]   line, line_next;
  logic [LENGTH_WIDTH-1:0] run, run_next;
  logic [7:0]              word_chars [WORD_DEPTH];
  logic [8*WORD_DEPTH-1:0] word_flat;
  logic [7:0]              pend_op, pend_op_next;
  logic                    wr_word;
  logic [2:0]              wr_idx;

  token_t tk [3];
  logic [1:0] cnt;

  always_comb begin
    for (int i = 0; i < WORD_DEPTH; i++) word_flat[8*i +: 8] = word_chars[i];
  end

  always_comb begin
    logic [7:0] c;
    logic       flush, restart, eol;
    logic [LINE_WIDTH-1:0] ln;
    c = item.char_byte;
    mode_next = mode; tok_begin_next = tok_begin; line_next = line;
    run_next = run; pend_op_next = pend_op;
    wr_word = 1'b0; wr_idx = '0;
    cnt = 2'd0; flush = 1'b0; restart = 1'b0; eol = 1'b0;
    for (int i = 0; i < 3; i++) tk[i] = '0;

    if (item.end_marker) begin
      flush = 1'b1;
    end else begin
      case (mode)
        M_IDENT:
          if (is_alpha(c) || is_digit(c)) begin
            if (run < LENGTH_WIDTH'(WORD_DEPTH)) begin
              wr_word = 1'b1; wr_idx = run[2:0];
            end
            run_next = len_inc(run);
          end else begin flush = 1'b1; restart = 1'b1; end
        M_NUMBER:
          if (is_digit(c)) run_next = len_inc(run);
          else if (c == ".") mode_next = M_NUMDOT;
          else begin flush = 1'b1; restart = 1'b1; end
        M_NUMDOT:
          if (is_digit(c)) begin
            run_next = len_inc(len_inc(run)); mode_next = M_FRACTION;
          end else begin flush = 1'b1; restart = 1'b1; end
        M_FRACTION:
          if (is_digit(c)) run_next = len_inc(run);
          else begin flush = 1'b1; restart = 1'b1; end
        M_STRING: begin
          run_next = len_inc(run);
          if (c == "\"") begin
            tk[0] = '{K_STRING, tok_begin, len_inc(run), line, 1'b0};
            cnt = 2'd1; mode_next = M_IDLE;
          end else if (c == "\n") line_next = line_inc(line);
        end
        M_SLASH:
          if (c == "/") mode_next = M_COMMENT;
          else begin flush = 1'b1; restart = 1'b1; end
        M_COMMENT:
          if (c == "\n") begin line_next = line_inc(line); mode_next = M_IDLE; end
        M_OP2:
          if (c == "=") begin
            tk[0] = '{op2_kind(pend_op, 1'b1), tok_begin, LENGTH_WIDTH'(2), line, 1'b0};
            cnt = 2'd1; mode_next = M_IDLE;
          end else begin flush = 1'b1; restart = 1'b1; end
        default: restart = 1'b1;
      endcase
    end

    if (flush) begin
      mode_next = M_IDLE;
      case (mode)
        M_IDENT: begin
          tk[0] = '{ident_kind(word_flat, run), tok_begin, run, line, 1'b0}; cnt = 2'd1;
        end
        M_NUMBER, M_FRACTION: begin
          tk[0] = '{K_NUMBER, tok_begin, run, line, 1'b0}; cnt = 2'd1;
        end
        M_NUMDOT: begin
          tk[0] = '{K_NUMBER, tok_begin, run, line, 1'b0};
          tk[1] = '{K_DOT, pos - 1'b1, LENGTH_WIDTH'(1), line, 1'b0};
          cnt = 2'd2;
        end
        M_STRING:
          if (item.end_marker) begin
            tk[0] = '{K_UNTERM, tok_begin, run, line, 1'b0}; cnt = 2'd1;
          end
        M_SLASH: begin
          tk[0] = '{K_SLASH, tok_begin, LENGTH_WIDTH'(1), line, 1'b0}; cnt = 2'd1;
        end
        M_OP2: begin
          tk[0] = '{op2_kind(pend_op, 1'b0), tok_begin, LENGTH_WIDTH'(1), line, 1'b0};
          cnt = 2'd1;
        end
        default: ;
      endcase
    end

    if (item.end_marker) begin
      tk[cnt] = '{K_EOF, pos, LENGTH_WIDTH'(0), line, 1'b0};
      cnt = cnt + 2'd1;
    end else if (restart) begin
      mode_next = M_IDLE;
      if (c == " " || c == "\r" || c == "\t") begin
        eol = 1'b0;
      end else if (c == "\n") begin
        eol = 1'b1;
      end else begin
        tok_begin_next = pos;
        run_next = LENGTH_WIDTH'(1);
        if (is_alpha(c)) begin
          mode_next = M_IDENT; wr_word = 1'b1; wr_idx = '0;
        end else if (is_digit(c)) mode_next = M_NUMBER;
        else if (c == "\"") mode_next = M_STRING;
        else if (c == "/") mode_next = M_SLASH;
        else if (c == "!" || c == "=" || c == "<" || c == ">") begin
          mode_next = M_OP2; pend_op_next = c;
        end else begin
          tk[cnt] = '{single_kind(c), pos, LENGTH_WIDTH'(1), line, 1'b0};
          cnt = cnt + 2'd1;
        end
      end
      if (eol) line_next = line_inc(line);
    end

    // Emitted tokens carry the line as it was before this character.
    ln = line;
    if (cnt != 2'd0) tk[cnt - 2'd1].last_of_run = 1'b1;
    tk[0].token_line = (cnt > 2'd0) ? ln : '0;
    group = '{cnt, tk[0], tk[1], tk[2]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= M_IDLE; tok_begin <= '0; pos <= '0;
      line <= LINE_WIDTH'(1); run <= '0; pend_op <= '0;
    end else if (take) begin
      if (item.end_marker) begin
        mode <= M_IDLE; tok_begin <= '0; pos <= '0;
        line <= LINE_WIDTH'(1); run <= '0; pend_op <= '0;
      end else begin
        mode <= mode_next; tok_begin <= tok_begin_next; pos <= pos + 1'b1;
        line <= line_next; run <= run_next; pend_op <= pend_op_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && !item.end_marker && wr_word) word_chars[wr_idx] <= item.char_byte;
  end

`ifndef SYNTHESIS
  a_line_nonzero: assert property (@(posedge clk) disable iff (rst) line != '0)
    else $error("line counter reached zero");
  a_eof_resets: assert property (@(posedge clk) disable iff (rst)
    take && item.end_marker |=> pos == '0 && mode == M_IDLE)
    else $error("end marker did not reset scanner");
  a_count_bound: assert property (@(posedge clk) disable iff (rst) group.count != 2'd3 ||
    item.end_marker || mode == M_NUMDOT)
    else $error("three tokens outside number-dot case");
`endif

endmodule

[rtl/sts_queue.sv]
// Token queue and serializer: buffers token groups, releases one token per cycle while out_ready is high.
// Depends on sts_pkg.
`timescale 1ns / 1ps
module sts_queue import sts_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  token_group_t group,
  output logic         room,
  output logic         out_valid,
  input  logic         out_ready,
  output token_t       out_tok
);

  token_t mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wp, rp;
  logic [QUEUE_AW:0]   fill, fill_next;
  logic [1:0]          n;
  logic                pop;

  assign n         = push ? group.count : 2'd0;
  assign out_valid = fill != '0;
  assign out_tok   = mem[rp];
  assign pop       = out_valid && out_ready;
  // Room for a worst-case group of three.
  assign room      = fill <= (QUEUE_AW+1)'(QUEUE_DEPTH - 3);
  assign fill_next = fill + (QUEUE_AW+1)'(n) - (QUEUE_AW+1)'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0; rp <= '0; fill <= '0;
    end else begin
      wp <= wp + QUEUE_AW'(n);
      if (pop) rp <= rp + 1'b1;
      fill <= fill_next;
    end
  end

  always_ff @(posedge clk) begin
    if (n > 2'd0) mem[wp] <= group.t0;
    if (n > 2'd1) mem[wp + 3'd1] <= group.t1;
    if (n > 2'd2) mem[wp + 3'd2] <= group.t2;
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    fill <= (QUEUE_AW+1)'(QUEUE_DEPTH))
    else $error("token queue overflow");
  a_push_room: assert property (@(posedge clk) disable iff (rst) push |-> room)
    else $error("push without room");
  a_fill_track: assert property (@(posedge clk) disable iff (rst)
    !rst |=> fill == $past(fill_next))
    else $error("fill count mismatch");
`endif

endmodule

[rtl/script_token_scanner.sv]
// Top level of the script token scanner: front end plus token queue.
// Depends on sts_pkg, sts_front and sts_queue.
`timescale 1ns / 1ps
// Usage:
//   in_valid/in_ready/in_data carry one source character (or the end marker)
//   per transaction. out_valid/out_ready/out_data carry one token per
//   transaction; last_of_run flags the final token caused by a character.
//   A character is scanned in the cycle it is accepted; the tokens it ends
//   are queued then and reach out_data behind any tokens already queued.
//   Throughput is one character per cycle while the eight-entry token queue
//   has room for three more tokens; output is one token per cycle while
//   out_ready is high, so a character that ends three tokens releases them in turn.
//   When the receiver stalls, the queue fills and in_ready drops until room
//   returns; nothing is lost.
//   Reset (rst, synchronous) empties the queue and puts the scanner at
//   offset 0, line 1. The end marker flushes any open token, emits EOF and
//   returns the scanner to that same start state.
module script_token_scanner import sts_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  char_item_t in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output token_t     out_data
);

  token_group_t group;
  logic         take;

  assign take = in_valid && in_ready;

  sts_front u_front (
    .clk(clk), .rst(rst), .take(take), .item(in_data), .group(group)
  );

  sts_queue u_queue (
    .clk(clk), .rst(rst), .push(take), .group(group), .room(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .out_tok(out_data)
  );

endmodule
